// File: sv/dvft_pkg.sv
// Shared types and constants for the distinct vector frequency table.
// Holds the request, result and search-wave structs and the operation codes.
// No dependencies.
`default_nettype none
package dvft_pkg;

  localparam int KEY_FIELDS   = 4;
  localparam int FIELD_BITS   = 16;
  localparam int MAX_DIMS     = 4;
  localparam int DIMS_LIMIT   = (MAX_DIMS < KEY_FIELDS) ? MAX_DIMS : KEY_FIELDS;
  localparam int DEF_ENTRIES  = 256;
  localparam int DEF_KEY_BITS = 16;

  localparam logic [2:0] KEY_DIMS_RESET = 3'd4;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] key_0;
    logic [15:0] key_1;
    logic [15:0] key_2;
    logic [15:0] key_3;
    logic [15:0] weight;
  } request_t;

  typedef struct packed {
    logic [7:0]  entry_index;
    logic        found;
    logic        table_full;
    logic [31:0] frequency;
    logic [8:0]  distinct_count;
  } result_t;

  // One request travelling down the row of entry cells.
  typedef struct packed {
    logic                                   valid;
    logic                                   insert;
    logic [KEY_FIELDS-1:0][FIELD_BITS-1:0]  key;
    logic [15:0]                            weight;
    logic                                   resolved;
    logic                                   found;
    logic [7:0]                             index;
    logic [31:0]                            frequency;
  } wave_t;

endpackage
`default_nettype wire

// File: sv/distinct_vector_frequency_table.sv
// Top level of the distinct vector frequency table: request launch, row of
// entry cells, entry count and result register. Depends on dvft_pkg, dvft_cell.
//
//   channel   ports                        handshake
//   request   start, busy, request         taken when start && !busy
//   result    done, result                 one-cycle strobe, never stalled
//   config    cfg_valid, cfg_ready, cfg_data  taken when both high
//
// Insert and lookup walk the row one cell a cycle: busy stays high while the
// request passes the launch register and every cell, and the result strobes
// in the cycle busy drops; only then can a new request be taken.
// Clear and the unused code finish at once: result the next cycle, no busy.
// Reset clears the entry count and sets key_dims to 4; stored keys need no
// clearing. The result side cannot stall, so results never back up.
`default_nettype none
module distinct_vector_frequency_table
  import dvft_pkg::*;
#(
  parameter int ENTRIES  = DEF_ENTRIES,
  parameter int KEY_BITS = DEF_KEY_BITS
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  output logic          busy,
  input  wire request_t request,
  output logic          done,
  output result_t       result,
  input  wire logic     cfg_valid,
  output logic          cfg_ready,
  input  wire logic [2:0] cfg_data
);

  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int SKB   = (KEY_BITS < FIELD_BITS) ? KEY_BITS : FIELD_BITS;
  localparam logic [FIELD_BITS-1:0] KEY_MASK = FIELD_BITS'((32'd1 << SKB) - 32'd1);

  logic [2:0]            key_dims;
  logic [2:0]            dims;
  logic [KEY_FIELDS-1:0] dim_mask;
  logic [CNT_W-1:0]      used;
  logic [CNT_W-1:0]      used_next;
  logic                  accept;
  logic                  tail_added;
  result_t               result_next;
  logic                  done_next;
  logic                  busy_next;
  wave_t                 launch_next;

  wave_t chain [ENTRIES+1];

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_comb begin
    if (key_dims == 3'd0) begin
      dims = 3'd1;
    end else if (key_dims > 3'(DIMS_LIMIT)) begin
      dims = 3'(DIMS_LIMIT);
    end else begin
      dims = key_dims;
    end
    for (int d = 0; d < KEY_FIELDS; d++) begin
      dim_mask[d] = (3'(d) < dims);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_dims <= KEY_DIMS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      key_dims <= cfg_data;
    end
  end

  // launch register feeding the first cell
  always_comb begin
    launch_next           = '0;
    launch_next.insert    = (request.operation == OP_INSERT);
    launch_next.key[0]    = request.key_0 & KEY_MASK;
    launch_next.key[1]    = request.key_1 & KEY_MASK;
    launch_next.key[2]    = request.key_2 & KEY_MASK;
    launch_next.key[3]    = request.key_3 & KEY_MASK;
    launch_next.weight    = request.weight;
    launch_next.valid     = accept &&
                            ((request.operation == OP_INSERT) ||
                             (request.operation == OP_LOOKUP));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0] <= '0;
    end else begin
      chain[0] <= launch_next;
    end
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    dvft_cell #(
      .ENTRIES  (ENTRIES),
      .KEY_BITS (KEY_BITS),
      .INDEX    (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .wave_in  (chain[i]),
      .used     (used),
      .dim_mask (dim_mask),
      .wave_out (chain[i+1])
    );
  end

  always_comb begin
    tail_added  = chain[ENTRIES].insert && chain[ENTRIES].resolved &&
                  !chain[ENTRIES].found;
    used_next   = used;
    result_next = '0;
    done_next   = 1'b0;
    busy_next   = busy;
    if (chain[ENTRIES].valid) begin
      if (tail_added) begin
        used_next = used + CNT_W'(1);
      end
      result_next.entry_index    = chain[ENTRIES].index;
      result_next.found          = chain[ENTRIES].found;
      result_next.table_full     = chain[ENTRIES].insert && !chain[ENTRIES].resolved;
      result_next.frequency      = chain[ENTRIES].frequency;
      result_next.distinct_count = 9'(used_next);
      done_next                  = 1'b1;
      busy_next                  = 1'b0;
    end else if (accept) begin
      case (request.operation)
        OP_INSERT, OP_LOOKUP: begin
          busy_next = 1'b1;
        end
        OP_CLEAR: begin
          used_next = '0;
          done_next = 1'b1;
        end
        default: begin
          result_next.distinct_count = 9'(used);
          done_next                  = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
    if (rst) begin
      used <= '0;
      done <= 1'b0;
      busy <= 1'b0;
    end else begin
      used <= used_next;
      done <= done_next;
      busy <= busy_next;
    end
  end

endmodule
`default_nettype wire

// File: sv/dvft_cell.sv
// One entry cell of the table: stores a key and its frequency, compares the
// passing request and hands it on to the next cell. Depends on dvft_pkg.
`default_nettype none
module dvft_cell
  import dvft_pkg::*;
#(
  parameter int ENTRIES  = DEF_ENTRIES,
  parameter int KEY_BITS = DEF_KEY_BITS,
  parameter int INDEX    = 0
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire wave_t                                wave_in,
  input  wire logic [$clog2(ENTRIES+1)-1:0]         used,
  input  wire logic [KEY_FIELDS-1:0]                dim_mask,
  output wave_t                                     wave_out
);

  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int SKB   = (KEY_BITS < FIELD_BITS) ? KEY_BITS : FIELD_BITS;
  localparam logic [CNT_W-1:0] MY_INDEX = CNT_W'(INDEX);
  localparam logic [7:0]       MY_INDEX8 = 8'(INDEX);

  logic [KEY_FIELDS-1:0][SKB-1:0] key_store;
  logic [31:0]                    freq;

  wave_t                 wave_next;
  logic [KEY_FIELDS-1:0] eq;
  logic                  live;
  logic                  match;
  logic                  is_append;
  logic [32:0]           sum;
  logic [31:0]           sat;
  logic                  key_we;
  logic                  freq_we;
  logic [31:0]           freq_wdata;

  always_comb begin
    for (int d = 0; d < KEY_FIELDS; d++) begin
      eq[d] = (key_store[d] == wave_in.key[d][SKB-1:0]);
    end
    live      = (MY_INDEX < used);
    match     = &(~dim_mask | eq);
    is_append = (MY_INDEX == used);
    sum       = {1'b0, freq} + {17'b0, wave_in.weight};
    sat       = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  end

  always_comb begin
    wave_next  = wave_in;
    key_we     = 1'b0;
    freq_we    = 1'b0;
    freq_wdata = sat;
    if (wave_in.valid && !wave_in.resolved) begin
      if (live && match) begin
        wave_next.resolved = 1'b1;
        wave_next.found    = 1'b1;
        wave_next.index    = MY_INDEX8;
        if (wave_in.insert) begin
          wave_next.frequency = sat;
          freq_we             = 1'b1;
        end else begin
          wave_next.frequency = freq;
        end
      end else if (wave_in.insert && is_append) begin
        wave_next.resolved  = 1'b1;
        wave_next.index     = MY_INDEX8;
        wave_next.frequency = {16'b0, wave_in.weight};
        key_we              = 1'b1;
        freq_we             = 1'b1;
        freq_wdata          = {16'b0, wave_in.weight};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      for (int d = 0; d < KEY_FIELDS; d++) begin
        key_store[d] <= wave_in.key[d][SKB-1:0];
      end
    end
    if (freq_we) begin
      freq <= freq_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_out <= '0;
    end else begin
      wave_out <= wave_next;
    end
  end

endmodule
`default_nettype wire

// File: tb/frequency_table_checker.sv
// Checker for the distinct vector frequency table: watches the request, result
// and key_dims channels, predicts each reply and compares it field by field.
// Depends on dvft_pkg.
`default_nettype none
module frequency_table_checker
  import dvft_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire logic       busy,
  input  wire request_t   request,
  input  wire logic       done,
  input  wire result_t    result,
  input  wire logic       cfg_valid,
  input  wire logic       cfg_ready,
  input  wire logic [2:0] cfg_data,
  output int              fails,
  output int              pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [15:0] stored_key [DEF_ENTRIES][KEY_FIELDS];
  logic [31:0] stored_freq [DEF_ENTRIES];
  int unsigned n_used;
  logic [2:0]  dims_reg;
  result_t     table_replies [$];
  result_t     owed;

  function automatic result_t tally_vector(request_t req);
    logic [15:0] probe [KEY_FIELDS];
    int unsigned dims;
    int unsigned hit_at;
    int unsigned e;
    int unsigned d;
    logic        hit;
    logic        same;
    logic [32:0] sum;
    result_t     r;
    probe[0] = req.key_0;
    probe[1] = req.key_1;
    probe[2] = req.key_2;
    probe[3] = req.key_3;
    dims = (dims_reg == 3'd0) ? 1 : ((dims_reg > DIMS_LIMIT) ? DIMS_LIMIT : dims_reg);
    r = '0;
    hit = 1'b0;
    hit_at = 0;
    for (e = 0; e < n_used && !hit; e++) begin
      same = 1'b1;
      for (d = 0; d < dims; d++) begin
        if (stored_key[e][d] != probe[d]) same = 1'b0;
      end
      if (same) begin
        hit = 1'b1;
        hit_at = e;
      end
    end
    case (req.operation)
      OP_INSERT: begin
        if (hit) begin
          sum = {1'b0, stored_freq[hit_at]} + {17'd0, req.weight};
          stored_freq[hit_at] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
          r.found = 1'b1;
          r.entry_index = 8'(hit_at);
          r.frequency = stored_freq[hit_at];
        end else if (n_used < DEF_ENTRIES) begin
          for (d = 0; d < KEY_FIELDS; d++) stored_key[n_used][d] = probe[d];
          stored_freq[n_used] = {16'd0, req.weight};
          r.entry_index = 8'(n_used);
          r.frequency = {16'd0, req.weight};
          n_used++;
        end else begin
          r.table_full = 1'b1;
        end
      end
      OP_LOOKUP: begin
        if (hit) begin
          r.found = 1'b1;
          r.entry_index = 8'(hit_at);
          r.frequency = stored_freq[hit_at];
        end
      end
      OP_CLEAR: n_used = 0;
      default: ;
    endcase
    r.distinct_count = 9'(n_used);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      n_used = 0;
      dims_reg = KEY_DIMS_RESET;
      table_replies.delete();
    end else begin
      if (cfg_valid && cfg_ready) dims_reg = cfg_data;
      if (done) begin
        if (table_replies.size() == 0) begin
          if (fails < 10) $display("unexpected reply at %0t: %p", $realtime, result);
          fails++;
        end else begin
          owed = table_replies.pop_front();
          if (result.entry_index !== owed.entry_index || result.found !== owed.found ||
              result.table_full !== owed.table_full || result.frequency !== owed.frequency ||
              result.distinct_count !== owed.distinct_count) begin
            if (fails < 10) begin
              $display("reply mismatch at %0t: exp idx=%0d found=%0b full=%0b freq=%0d cnt=%0d",
                       $realtime, owed.entry_index, owed.found, owed.table_full,
                       owed.frequency, owed.distinct_count);
              $display("  got idx=%0d found=%0b full=%0b freq=%0d cnt=%0d",
                       result.entry_index, result.found, result.table_full,
                       result.frequency, result.distinct_count);
            end
            fails++;
          end
        end
      end
      if (start && !busy) table_replies.push_back(tally_vector(request));
    end
    pending = table_replies.size();
  end

endmodule
`default_nettype wire

// File: tb/tb_distinct_vector_frequency_table.sv
// Top of the frequency table testbench: clock, reset, directed and random
// requests, key_dims writes and the verdict.
// Depends on dvft_pkg, distinct_vector_frequency_table, frequency_table_checker.
`default_nettype none
module tb_distinct_vector_frequency_table
  import dvft_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int TARGET_ITEMS = 1100;
  localparam int FILL_EXTRA = 12;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  request_t    request = '0;
  logic        done;
  result_t     result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_data = '0;
  int          fails;
  int          pending;
  int unsigned cycles = 0;
  int unsigned issued = 0;
  bit          steady = 1'b0;
  logic [15:0] comp_pool [KEY_FIELDS][2];
  logic [15:0] fill_tail [3];
  int unsigned phase;
  int unsigned n;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  distinct_vector_frequency_table dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  frequency_table_checker checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_data(cfg_data), .fails(fails), .pending(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic request_t pack_request(logic [1:0] op, logic [15:0] k0, logic [15:0] k1,
                                            logic [15:0] k2, logic [15:0] k3,
                                            logic [15:0] w);
    request_t r;
    r.operation = op;
    r.key_0 = k0;
    r.key_1 = k1;
    r.key_2 = k2;
    r.key_3 = k3;
    r.weight = w;
    return r;
  endfunction

  function automatic logic [15:0] pick_weight();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 6) return 16'd0;
    else if (r < 14) return 16'hFFFF;
    else return 16'($urandom_range(1, 65535));
  endfunction

  function automatic request_t pool_request();
    int unsigned r;
    int unsigned d;
    logic [1:0]  op;
    logic [15:0] k [KEY_FIELDS];
    r = $urandom_range(0, 99);
    op = (r < 55) ? OP_INSERT : (r < 87) ? OP_LOOKUP : (r < 93) ? OP_CLEAR : OP_SPARE;
    for (d = 0; d < KEY_FIELDS; d++)
      k[d] = ($urandom_range(0, 11) == 0) ? 16'($urandom) : comp_pool[d][$urandom_range(0, 1)];
    return pack_request(op, k[0], k[1], k[2], k[3], pick_weight());
  endfunction

  task automatic pause(int unsigned cnt);
    logic [95:0] junk;
    repeat (cnt) begin
      @(negedge clk);
      junk = {$urandom, $urandom, $urandom};
      start = 1'b0;
      request = junk[$bits(request_t)-1:0];
    end
  endtask

  task automatic send(request_t req);
    int unsigned r;
    @(negedge clk);
    start = 1'b1;
    request = req;
    do @(posedge clk); while (busy);
    issued++;
    r = $urandom_range(0, 99);
    if (!steady && r >= 55) begin
      if (r < 90) pause($urandom_range(1, 3));
      else pause($urandom_range(12, 60));
    end
  endtask

  task automatic drain();
    pause(1);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_dims(logic [2:0] v);
    drain();
    pause($urandom_range(0, 3));
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic refresh_pool();
    int unsigned d;
    int unsigned j;
    for (d = 0; d < KEY_FIELDS; d++)
      for (j = 0; j < 2; j++)
        case ($urandom_range(0, 7))
          0: comp_pool[d][j] = 16'h0000;
          1: comp_pool[d][j] = 16'hFFFF;
          default: comp_pool[d][j] = 16'($urandom);
        endcase
  endtask

  task automatic fill_table();
    int unsigned i;
    for (i = 0; i < 3; i++) fill_tail[i] = 16'($urandom);
    send(pack_request(OP_CLEAR, '0, '0, '0, '0, '0));
    for (i = 0; i < DEF_ENTRIES + FILL_EXTRA; i++) begin
      send(pack_request(OP_INSERT, 16'(i), fill_tail[0], fill_tail[1], fill_tail[2],
                        pick_weight()));
      if (i % 32 == 31)
        send(pack_request(OP_LOOKUP, 16'($urandom_range(0, i)), fill_tail[0], fill_tail[1],
                          fill_tail[2], pick_weight()));
    end
    for (i = 0; i < 6; i++) begin
      send(pack_request(OP_INSERT, 16'($urandom_range(0, DEF_ENTRIES - 1)), fill_tail[0],
                        fill_tail[1], fill_tail[2], pick_weight()));
      send(pack_request(OP_LOOKUP, 16'($urandom_range(0, 65535)), fill_tail[0],
                        fill_tail[1], fill_tail[2], pick_weight()));
    end
    send(pack_request(OP_SPARE, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom)));
    send(pack_request(OP_CLEAR, '0, '0, '0, '0, '0));
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst = 1'b0;

    send(pack_request(OP_LOOKUP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send(pack_request(OP_INSERT, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd1));
    send(pack_request(OP_INSERT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send(pack_request(OP_INSERT, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF));
    send(pack_request(OP_INSERT, 16'd1, 16'd2, 16'd3, 16'd4, 16'd0));
    send(pack_request(OP_INSERT, 16'd1, 16'd2, 16'd3, 16'd4, 16'd0));
    send(pack_request(OP_LOOKUP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0));
    send(pack_request(OP_LOOKUP, 16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'd5));
    send(pack_request(OP_SPARE, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom)));
    send(pack_request(OP_INSERT, 16'd7, 16'd1, 16'd0, 16'd0, 16'd5));
    send(pack_request(OP_INSERT, 16'd7, 16'd2, 16'd0, 16'd0, 16'd6));
    send(pack_request(OP_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send(pack_request(OP_LOOKUP, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd0));
    send(pack_request(OP_INSERT, 16'd1, 16'd2, 16'd3, 16'd4, 16'd9));
    send(pack_request(OP_INSERT, 16'd7, 16'd1, 16'd0, 16'd0, 16'd5));
    send(pack_request(OP_INSERT, 16'd7, 16'd2, 16'd0, 16'd0, 16'd6));
    write_dims(3'd1);
    send(pack_request(OP_LOOKUP, 16'd7, 16'd9, 16'd9, 16'd9, 16'd0));
    send(pack_request(OP_INSERT, 16'd1, 16'hAAAA, 16'h5555, 16'h0000, 16'd3));
    write_dims(3'd0);
    send(pack_request(OP_LOOKUP, 16'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0));
    write_dims(3'd7);
    send(pack_request(OP_LOOKUP, 16'd1, 16'd2, 16'd3, 16'd4, 16'd0));
    send(pack_request(OP_LOOKUP, 16'd1, 16'hAAAA, 16'h5555, 16'h0000, 16'd0));
    send(pack_request(OP_SPARE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));

    phase = 0;
    while (issued < TARGET_ITEMS) begin
      if (phase == 3) begin
        write_dims(3'($urandom_range(0, 7)));
        steady = 1'b0;
        fill_table();
      end
      write_dims((phase < 8) ? 3'(phase) : 3'($urandom_range(0, 7)));
      steady = ($urandom_range(0, 3) == 0);
      refresh_pool();
      n = $urandom_range(30, 90);
      repeat (n) send(pool_request());
      phase++;
    end

    steady = 1'b0;
    drain();
    repeat (DEF_ENTRIES + 8) @(negedge clk);
    if (fails == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: filelist.f
sv/dvft_pkg.sv
sv/dvft_cell.sv
sv/distinct_vector_frequency_table.sv
tb/frequency_table_checker.sv
tb/tb_distinct_vector_frequency_table.sv
